// ----- hdl/fth_pkg.sv -----
// Package for the flow tuple hash table: sizes, mode/status codes, hash functions.
// No dependencies.
`timescale 1ns / 1ps
package fth_pkg;
   localparam int DEF_BINS  = 1024;
   localparam int DEF_WAYS  = 4;
   localparam int KEY_W     = 96;
   localparam int HANDLE_W  = 16;
   localparam int COUNT_W   = 13;
   localparam int BIN_OUT_W = 10;
   localparam int KEY_BYTES = 12;

   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_REMOVE = 2'd1;
   localparam logic [1:0] MODE_SEARCH = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOTFOUND = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;

   typedef struct packed {
      logic hash_load;
      logic hash_step;
      logic clear;
      logic way_check;
      logic commit;
   } ctl_type;

   typedef struct packed {
      logic hash_last;
      logic way_last;
      logic hit;
      logic clear_last;
   } sts_type;

   function automatic logic [31:0] oaat_round(input logic [31:0] h, input logic [7:0] b);
      logic [31:0] t;
      t = h + {{24{b[7]}}, b};
      t = t + (t << 10);
      t = t ^ (t >> 6);
      return t;
   endfunction

   function automatic logic [31:0] oaat_final(input logic [31:0] h);
      logic [31:0] t;
      t = h + (h << 3);
      t = t ^ (t >> 11);
      t = t + (t << 15);
      return t;
   endfunction
endpackage

// ----- hdl/fth_ram.sv -----
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module fth_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

// ----- hdl/fth_ctrl.sv -----
// Sequencer for the hash table: clearing pass, hash rounds, way scan, commit, result strobe.
// Depends on fth_pkg.
`timescale 1ns / 1ps
module fth_ctrl import fth_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  sts_type sts,
   output ctl_type ctl,
   output logic    busy,
   output logic    rsp_valid
);
   localparam logic [2:0] S_IDLE = 3'd0, S_HASH = 3'd1, S_READ = 3'd2, S_WAIT = 3'd3,
                          S_CHECK = 3'd4, S_COMMIT = 3'd5, S_CLEAR = 3'd6;
   logic [2:0] state_ff, state_in;
   logic       rsp_ff, rsp_in;

   always_comb begin
      state_in = state_ff;
      rsp_in   = 1'b0;
      ctl      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            ctl.clear = 1'b1;
            if (sts.clear_last) state_in = S_IDLE;
         end
         S_IDLE: if (start && !rsp_ff) begin
            ctl.hash_load = 1'b1;
            state_in = S_HASH;
         end
         S_HASH: begin
            ctl.hash_step = 1'b1;
            if (sts.hash_last) state_in = S_READ;
         end
         S_READ: state_in = S_WAIT;
         S_WAIT: state_in = S_CHECK;
         S_CHECK: begin
            ctl.way_check = 1'b1;
            if (sts.hit || sts.way_last) state_in = S_COMMIT;
            else state_in = S_READ;
         end
         S_COMMIT: begin
            ctl.commit = 1'b1;
            rsp_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         rsp_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_ff   <= rsp_in;
      end
   end

   assign busy      = (state_ff != S_IDLE) || rsp_ff;
   assign rsp_valid = rsp_ff;
endmodule

// ----- hdl/fth_dpath.sv -----
// Datapath: hash unit, way counter, key/handle/valid RAMs, clear counter, live count.
// Depends on fth_pkg and fth_ram.
`timescale 1ns / 1ps
module fth_dpath import fth_pkg::*; #(
   parameter int BINS = DEF_BINS,
   parameter int WAYS = DEF_WAYS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ctl_type              ctl,
   output sts_type              sts,
   input  logic [1:0]           req_mode,
   input  logic [63:0]          req_key_lo,
   input  logic [31:0]          req_key_hi,
   input  logic [HANDLE_W-1:0]  req_handle,
   output logic [1:0]           rsp_status,
   output logic [HANDLE_W-1:0]  rsp_found_handle,
   output logic [BIN_OUT_W-1:0] rsp_bin_index,
   output logic [COUNT_W-1:0]   rsp_entry_count
);
   localparam int ENTRIES = BINS * WAYS;
   localparam int EW = $clog2(ENTRIES);
   localparam int BW = (BINS > 1) ? $clog2(BINS) : 1;
   localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int BYTE_W = $clog2(KEY_BYTES);
   localparam logic [31:0] BMASK = 32'(BINS - 1);

   logic [1:0]          mode_ff;
   logic [KEY_W-1:0]    key_ff;
   logic [HANDLE_W-1:0] hd_ff;
   logic [31:0]         h_ff, h_in;
   logic [BYTE_W-1:0]   byte_ff;
   logic [BW-1:0]       bin_ff;
   logic [WW-1:0]       way_ff;
   logic                done_ff, done_in;
   logic [WW-1:0]       sel_ff, sel_in;
   logic [1:0]          status_ff, status_in;
   logic [HANDLE_W-1:0] found_ff, found_in;
   logic [COUNT_W-1:0]  count_ff;
   logic [EW-1:0]       clr_ff;
   logic [KEY_W-1:0]    rd_key;
   logic [HANDLE_W-1:0] rd_hd;
   logic                rd_vld;
   logic [EW-1:0]       addr, sel_addr, vld_addr;
   logic [31:0]         hmask, hfin;
   logic                vld, match, vld_we, vld_data;

   assign addr     = EW'(bin_ff) * EW'(WAYS) + EW'(way_ff);
   assign sel_addr = EW'(bin_ff) * EW'(WAYS) + EW'(sel_ff);
   assign hfin     = oaat_final(h_in);
   assign hmask    = hfin & BMASK;
   assign vld      = rd_vld;
   assign match    = vld && (rd_key == key_ff);

   assign sts.hash_last  = (byte_ff == BYTE_W'(KEY_BYTES - 1));
   assign sts.way_last   = (way_ff == WW'(WAYS - 1));
   assign sts.hit        = (mode_ff == MODE_INSERT) ? !vld : match;
   assign sts.clear_last = (clr_ff == EW'(ENTRIES - 1));

   logic ins_write;
   assign ins_write = ctl.commit && (mode_ff == MODE_INSERT) && done_ff;

   assign vld_we   = ctl.clear || (ctl.commit && done_ff &&
                     (mode_ff == MODE_INSERT || mode_ff == MODE_REMOVE));
   assign vld_addr = ctl.clear ? clr_ff : sel_addr;
   assign vld_data = !ctl.clear && (mode_ff == MODE_INSERT);

   fth_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key (
      .clock(clock), .wr_en(ins_write), .wr_addr(sel_addr), .wr_data(key_ff),
      .rd_addr(addr), .rd_data(rd_key));
   fth_ram #(.WIDTH(HANDLE_W), .DEPTH(ENTRIES)) u_hd (
      .clock(clock), .wr_en(ins_write), .wr_addr(sel_addr), .wr_data(hd_ff),
      .rd_addr(addr), .rd_data(rd_hd));
   fth_ram #(.WIDTH(1), .DEPTH(ENTRIES)) u_vld (
      .clock(clock), .wr_en(vld_we), .wr_addr(vld_addr), .wr_data(vld_data),
      .rd_addr(addr), .rd_data(rd_vld));

   always_comb begin
      h_in = h_ff;
      if (ctl.hash_step) h_in = oaat_round(h_ff, key_ff[8*byte_ff +: 8]);
      done_in   = done_ff;
      sel_in    = sel_ff;
      found_in  = found_ff;
      status_in = status_ff;
      if (ctl.hash_load) begin
         done_in = 1'b0;
         found_in = '0;
         status_in = (req_mode == MODE_INSERT) ? ST_FULL : ST_NOTFOUND;
      end else if (ctl.way_check && sts.hit) begin
         done_in = 1'b1;
         sel_in = way_ff;
         status_in = ST_OK;
         if (mode_ff != MODE_INSERT) found_in = rd_hd;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.hash_load) begin
         mode_ff <= req_mode;
         key_ff  <= {req_key_hi, req_key_lo};
         hd_ff   <= req_handle;
      end
      h_ff      <= ctl.hash_load ? 32'd0 : h_in;
      done_ff   <= done_in;
      sel_ff    <= sel_in;
      status_ff <= status_in;
      found_ff  <= found_in;
      if (ctl.hash_load) byte_ff <= '0;
      else if (ctl.hash_step && !sts.hash_last) byte_ff <= byte_ff + 1'b1;
      if (ctl.hash_step && sts.hash_last)
         bin_ff <= BW'((hmask >= 32'(BINS)) ? hmask - 32'(BINS) : hmask);
      if (ctl.hash_load) way_ff <= '0;
      else if (ctl.way_check && !sts.way_last) way_ff <= way_ff + 1'b1;
      if (reset) begin
         clr_ff   <= '0;
         count_ff <= '0;
      end else begin
         if (ctl.clear) clr_ff <= clr_ff + 1'b1;
         if (ctl.commit && done_ff) begin
            if (mode_ff == MODE_INSERT) count_ff <= count_ff + 1'b1;
            else if (mode_ff == MODE_REMOVE) count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.commit) begin
         rsp_status       <= status_ff;
         rsp_found_handle <= found_ff;
         rsp_bin_index    <= BIN_OUT_W'(bin_ff);
         rsp_entry_count  <= count_ff + ((done_ff && mode_ff == MODE_INSERT) ? 13'd1 :
                             (done_ff && mode_ff == MODE_REMOVE) ? 13'h1FFF : 13'd0);
      end
   end
endmodule

// ----- hdl/flow_tuple_hash_table_unit.sv -----
// Channel | ports                                     | direction
// request | start, req_mode/key_lo/key_hi/handle; busy is out | in
// result  | rsp_valid, rsp_status/found_handle/bin_index/entry_count | out
// An item takes 12 hash rounds, then READ, WAIT and CHECK states per way scanned (registered
// RAM read), then a commit state and the result strobe; the way scan stops at the first hit.
// After reset a clearing pass zeroes all BINS*WAYS valid marks, with busy high.
// The receiver cannot stall; busy stays high until the result strobe has gone by.
// Top level: fth_ctrl and fth_dpath. Depends on fth_pkg.
`timescale 1ns / 1ps
module flow_tuple_hash_table_unit import fth_pkg::*; #(
   parameter int BINS = DEF_BINS,
   parameter int WAYS = DEF_WAYS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [1:0]           req_mode,
   input  logic [63:0]          req_key_lo,
   input  logic [31:0]          req_key_hi,
   input  logic [HANDLE_W-1:0]  req_handle,
   output logic                 rsp_valid,
   output logic [1:0]           rsp_status,
   output logic [HANDLE_W-1:0]  rsp_found_handle,
   output logic [BIN_OUT_W-1:0] rsp_bin_index,
   output logic [COUNT_W-1:0]   rsp_entry_count
);
   ctl_type ctl;
   sts_type sts;

   fth_ctrl u_ctrl (.clock(clock), .reset(reset), .start(start), .sts(sts), .ctl(ctl),
      .busy(busy), .rsp_valid(rsp_valid));

   fth_dpath #(.BINS(BINS), .WAYS(WAYS)) u_dpath (.clock(clock), .reset(reset),
      .ctl(ctl), .sts(sts), .req_mode(req_mode), .req_key_lo(req_key_lo),
      .req_key_hi(req_key_hi), .req_handle(req_handle), .rsp_status(rsp_status),
      .rsp_found_handle(rsp_found_handle), .rsp_bin_index(rsp_bin_index),
      .rsp_entry_count(rsp_entry_count));

   a_rsp_busy: assert property (@(posedge clock) disable iff (reset) rsp_valid |-> busy)
      else $error("result strobe while not busy");
   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe longer than one cycle");
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_OK || rsp_status == ST_NOTFOUND ||
                     rsp_status == ST_FULL)) else $error("bad status code");
   a_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> rsp_found_handle == '0)
      else $error("handle reported on miss");
endmodule
